// ===== src/idr_pkg.sv =====
// idr_pkg: shared types, constants and opcode helpers for the IMU reply deframer.
// No dependencies; used by idr_front, idr_back, imu_reply_deframer and idr_checker.
`default_nettype none

package idr_pkg;

    // Buffer depth default (top-level parameter BUFFER_BYTES)
    localparam int BUFFER_BYTES_DEF = 32;

    // Intake queue between front and back
    localparam int             QUEUE_DEPTH = 4;
    localparam int             QPW         = 2;
    localparam logic [QPW:0]   QUEUE_FULL  = 3'd4;

    // Opcodes
    localparam logic [7:0] OP_EULER      = 8'hCE;
    localparam logic [7:0] OP_EULER_RATE = 8'hCF;
    localparam logic [7:0] OP_DELTA      = 8'hC3;

    // Frame lengths, zero means not locked
    localparam logic [4:0] LEN_NONE  = 5'd0;
    localparam logic [4:0] LEN_SHORT = 5'd19;
    localparam logic [4:0] LEN_LONG  = 5'd31;
    // Frames at least this long carry words d..f
    localparam logic [4:0] LEN_FULL  = 5'd25;

    // Frame kinds
    localparam logic [1:0] KIND_EULER = 2'd0;
    localparam logic [1:0] KIND_RATE  = 2'd1;
    localparam logic [1:0] KIND_DELTA = 2'd2;

    // Result outcomes
    localparam logic OUTCOME_OK  = 1'b0;
    localparam logic OUTCOME_BAD = 1'b1;

    // Payload words and the last payload byte offset (words at 1,5,..,21)
    localparam int WORDS        = 6;
    localparam int PAYLOAD_LAST = 24;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SUM,
        ST_EMIT
    } t_state;

    // One queued word: the received byte and the frame length it would lock as an opcode
    typedef struct packed {
        logic [7:0] data;
        logic [4:0] len;
    } t_q_entry;

    function automatic logic [4:0] op_len(input logic [7:0] op);
        logic [4:0] len;
        case (op)
            OP_EULER:      len = LEN_SHORT;
            OP_EULER_RATE: len = LEN_LONG;
            OP_DELTA:      len = LEN_LONG;
            default:       len = LEN_NONE;
        endcase
        return len;
    endfunction

    function automatic logic [1:0] op_kind(input logic [7:0] op);
        logic [1:0] kind;
        case (op)
            OP_EULER:      kind = KIND_EULER;
            OP_EULER_RATE: kind = KIND_RATE;
            default:       kind = KIND_DELTA;
        endcase
        return kind;
    endfunction

endpackage

`default_nettype wire

// ===== src/idr_front.sv =====
// idr_front: input word intake, opcode classification and a small queue.
// Depends on idr_pkg.
`default_nettype none

module idr_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [7:0]         i_rx_byte,
    output logic                    o_q_valid,
    output idr_pkg::t_q_entry       o_q_entry,
    input  wire logic               i_q_pop
);

    idr_pkg::t_q_entry              r_q [idr_pkg::QUEUE_DEPTH];
    logic [idr_pkg::QPW-1:0]        r_wptr;
    logic [idr_pkg::QPW-1:0]        r_rptr;
    logic [idr_pkg::QPW:0]          r_count;
    logic                           push;
    logic                           pop;
    idr_pkg::t_q_entry              entry;

    assign o_in_stall = (r_count == idr_pkg::QUEUE_FULL);
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != '0);
    assign pop        = i_q_pop && o_q_valid;
    assign o_q_entry  = r_q[r_rptr];

    always_comb begin
        entry.data = i_rx_byte;
        entry.len  = idr_pkg::op_len(i_rx_byte);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/idr_back.sv =====
// idr_back: byte ring buffer, resync scan, checksum pass and result register.
// Depends on idr_pkg; fed by idr_front through its queue.
`default_nettype none

module idr_back #(
    parameter int BUFFER_BYTES = idr_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire idr_pkg::t_q_entry  i_q_entry,
    output logic                    o_q_pop,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_outcome,
    output logic [1:0]              o_frame_kind,
    output logic [31:0]             o_word_a,
    output logic [31:0]             o_word_b,
    output logic [31:0]             o_word_c,
    output logic [31:0]             o_word_d,
    output logic [31:0]             o_word_e,
    output logic [31:0]             o_word_f
);

    localparam int PW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int SW = CW + 1;
    localparam logic [CW-1:0] FILL_FULL = CW'(BUFFER_BYTES);

    // ring add, a below depth and b at most depth
    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a,
                                               input logic [CW-1:0] b);
        logic [SW-1:0] s;
        s = SW'(a) + SW'(b);
        if (s >= SW'(BUFFER_BYTES)) begin
            s = s - SW'(BUFFER_BYTES);
        end
        return s[PW-1:0];
    endfunction

    logic [7:0]             mem [BUFFER_BYTES];

    idr_pkg::t_state        r_state, n_state;
    logic [PW-1:0]          r_head, n_head;
    logic [CW-1:0]          r_fill, n_fill;
    logic [4:0]             r_len, n_len;
    logic [CW-1:0]          r_iss, n_iss;
    logic [PW-1:0]          r_rptr, n_rptr;
    logic [15:0]            r_sum, n_sum;
    logic [15:0]            r_trail, n_trail;
    logic [1:0]             r_kind, n_kind;
    logic                   r_dvld;
    logic [CW-1:0]          r_didx;
    logic [PW-1:0]          r_daddr;
    logic [7:0]             r_rdata;
    logic [31:0]            r_word [idr_pkg::WORDS];

    logic                   r_out_vld;
    logic                   r_outcome;
    logic [1:0]             r_out_kind;
    logic [31:0]            r_out_word [idr_pkg::WORDS];

    logic                   mem_we;
    logic [PW-1:0]          mem_waddr;
    logic [7:0]             mem_wdata;
    logic                   rd_en;

    logic                   locked;
    logic                   full;
    logic [CW-1:0]          fill_app;
    logic [CW-1:0]          len_cw;
    logic                   hit;
    logic                   last_scan;
    logic                   sum_last;
    logic                   match;
    logic                   out_free;
    logic                   emit_go;
    logic                   wide_frame;
    logic                   word_we;
    logic [CW-1:0]          k1;
    logic [2:0]             widx;
    logic [1:0]             lane;

    assign locked    = (r_len != idr_pkg::LEN_NONE);
    assign full      = (r_fill == FILL_FULL);
    assign fill_app  = full ? r_fill : r_fill + CW'(1);
    assign len_cw    = CW'(r_len);
    assign hit       = r_dvld && (idr_pkg::op_len(r_rdata) != idr_pkg::LEN_NONE);
    assign last_scan = r_dvld && (r_didx == r_fill - CW'(1));
    assign sum_last  = r_dvld && (r_didx == len_cw - CW'(1));
    assign match     = (r_sum == r_trail);
    assign out_free  = !r_out_vld || !i_out_stall;
    assign emit_go   = (r_state == idr_pkg::ST_EMIT) && out_free;
    assign o_q_pop   = (r_state == idr_pkg::ST_IDLE) && i_q_valid;
    assign wide_frame = (r_kind != idr_pkg::KIND_EULER) && (r_len >= idr_pkg::LEN_FULL);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            idr_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    if (!locked) begin
                        if (r_fill != '0) begin
                            n_state = idr_pkg::ST_SCAN;
                        end
                    end else if (fill_app >= len_cw) begin
                        n_state = idr_pkg::ST_SUM;
                    end
                end
            end
            idr_pkg::ST_SCAN: begin
                if (hit || last_scan) begin
                    n_state = idr_pkg::ST_IDLE;
                end
            end
            idr_pkg::ST_SUM: begin
                if (sum_last) begin
                    n_state = idr_pkg::ST_EMIT;
                end
            end
            idr_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = idr_pkg::ST_IDLE;
                end
            end
            default: n_state = idr_pkg::ST_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        n_head    = r_head;
        n_fill    = r_fill;
        n_len     = r_len;
        n_iss     = r_iss;
        n_rptr    = r_rptr;
        n_sum     = r_sum;
        n_trail   = r_trail;
        n_kind    = r_kind;
        mem_we    = 1'b0;
        mem_waddr = wrap_add(r_head, r_fill);
        mem_wdata = i_q_entry.data;
        rd_en     = 1'b0;
        case (r_state)
            idr_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    mem_we = !full;
                    n_fill = fill_app;
                    n_iss  = '0;
                    n_rptr = r_head;
                    n_sum  = '0;
                    if (!locked && r_fill == '0) begin
                        // empty buffer: the new byte is classified in the front
                        if (i_q_entry.len != idr_pkg::LEN_NONE) begin
                            n_len = i_q_entry.len;
                        end else begin
                            n_fill = '0;
                        end
                    end
                end
            end
            idr_pkg::ST_SCAN: begin
                if (hit) begin
                    n_len  = idr_pkg::op_len(r_rdata);
                    n_head = r_daddr;
                    n_fill = r_fill - r_didx;
                end else if (last_scan) begin
                    n_fill = '0;
                end else if (r_iss < r_fill) begin
                    rd_en  = 1'b1;
                    n_iss  = r_iss + CW'(1);
                    n_rptr = wrap_add(r_rptr, CW'(1));
                end
            end
            idr_pkg::ST_SUM: begin
                if (r_iss < len_cw) begin
                    rd_en  = 1'b1;
                    n_iss  = r_iss + CW'(1);
                    n_rptr = wrap_add(r_rptr, CW'(1));
                end
                if (r_dvld) begin
                    if (r_didx == '0) begin
                        n_kind = idr_pkg::op_kind(r_rdata);
                    end
                    if (r_didx < len_cw - CW'(2)) begin
                        n_sum = r_sum + 16'(r_rdata);
                    end
                    if (r_didx == len_cw - CW'(2)) begin
                        n_trail[15:8] = r_rdata;
                    end
                    if (r_didx == len_cw - CW'(1)) begin
                        n_trail[7:0] = r_rdata;
                    end
                end
            end
            idr_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_len = idr_pkg::LEN_NONE;
                    if (match) begin
                        n_head = wrap_add(r_head, len_cw);
                        n_fill = r_fill - len_cw;
                    end else begin
                        // zero the opcode so the next scan skips it
                        mem_we    = 1'b1;
                        mem_waddr = r_head;
                        mem_wdata = '0;
                    end
                end
            end
            default: begin
                n_len = idr_pkg::LEN_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= idr_pkg::ST_IDLE;
            r_head  <= '0;
            r_fill  <= '0;
            r_len   <= idr_pkg::LEN_NONE;
            r_iss   <= '0;
            r_rptr  <= '0;
            r_dvld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fill  <= n_fill;
            r_len   <= n_len;
            r_iss   <= n_iss;
            r_rptr  <= n_rptr;
            r_dvld  <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum   <= n_sum;
        r_trail <= n_trail;
        r_kind  <= n_kind;
        if (rd_en) begin
            r_didx  <= r_iss;
            r_daddr <= r_rptr;
        end
    end

    // buffer memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rdata <= mem[r_rptr];
        end
    end

    // payload bytes 1..24 land in big-endian word lanes
    assign k1      = r_didx - CW'(1);
    assign widx    = k1[4:2];
    assign lane    = 2'd3 - k1[1:0];
    assign word_we = (r_state == idr_pkg::ST_SUM) && r_dvld && (r_didx != '0) &&
                     (r_didx <= CW'(idr_pkg::PAYLOAD_LAST));

    always_ff @(posedge i_clk) begin
        if (word_we) begin
            r_word[widx][{lane, 3'b000} +: 8] <= r_rdata;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit_go) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_outcome  <= match ? idr_pkg::OUTCOME_OK : idr_pkg::OUTCOME_BAD;
            r_out_kind <= r_kind;
            if (match) begin
                r_out_word[0] <= r_word[0];
                r_out_word[1] <= r_word[1];
                r_out_word[2] <= r_word[2] ^ {(r_kind != idr_pkg::KIND_DELTA), 31'b0};
                r_out_word[3] <= wide_frame ? r_word[3] : '0;
                r_out_word[4] <= wide_frame ? r_word[4] : '0;
                r_out_word[5] <= wide_frame ? r_word[5] : '0;
            end else begin
                r_out_word[0] <= '0;
                r_out_word[1] <= '0;
                r_out_word[2] <= '0;
                r_out_word[3] <= '0;
                r_out_word[4] <= '0;
                r_out_word[5] <= '0;
            end
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_outcome    = r_outcome;
    assign o_frame_kind = r_out_kind;
    assign o_word_a     = r_out_word[0];
    assign o_word_b     = r_out_word[1];
    assign o_word_c     = r_out_word[2];
    assign o_word_d     = r_out_word[3];
    assign o_word_e     = r_out_word[4];
    assign o_word_f     = r_out_word[5];

endmodule

`default_nettype wire

// ===== src/imu_reply_deframer.sv =====
// imu_reply_deframer: with the back end idle, o_out_valid rises after the word that completes a
// frame (L = 19 or 31 bytes) is taken, once the checksum pass has run and the result register is
// loaded. A word holds the back end for a plain append, a checksum pass over the L frame bytes,
// or a resync scan over the fill after the append, reading through the buffer's single read port.
// Reset (synchronous, active low) empties queue and buffer and drops any lock;
// the buffer contents themselves are not cleared, no clearing pass is needed.
`default_nettype none

module imu_reply_deframer #(
    parameter int BUFFER_BYTES = idr_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // input channel: one received serial byte per word
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire logic [7:0]     i_rx_byte,
    // result channel
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output logic                o_outcome,
    output logic [1:0]          o_frame_kind,
    output logic [31:0]         o_word_a,
    output logic [31:0]         o_word_b,
    output logic [31:0]         o_word_c,
    output logic [31:0]         o_word_d,
    output logic [31:0]         o_word_e,
    output logic [31:0]         o_word_f
);

    // Front: takes words into a 4-deep queue and tags each with the frame
    // length its byte would lock if it were an opcode. It keeps taking words
    // while the back end scans or checks, so the serial side rarely stalls.
    //
    // Back: a ring buffer of BUFFER_BYTES bytes with a head pointer and fill
    // count, so dropping bytes from the front is just a pointer move.
    //   - unlocked: scan from head one byte a cycle for an opcode
    //   - locked, enough bytes: one pass over the frame summing all but the
    //     trailer, catching the trailer and the payload words
    //   - result: loaded into an output register that is held under stall
    // A checksum mismatch zeroes the opcode byte so the next scan moves past it.

    logic                   q_valid;
    idr_pkg::t_q_entry      q_entry;
    logic                   q_pop;

    idr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_rx_byte  (i_rx_byte),
        .o_q_valid  (q_valid),
        .o_q_entry  (q_entry),
        .i_q_pop    (q_pop)
    );

    idr_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_entry    (q_entry),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_outcome    (o_outcome),
        .o_frame_kind (o_frame_kind),
        .o_word_a     (o_word_a),
        .o_word_b     (o_word_b),
        .o_word_c     (o_word_c),
        .o_word_d     (o_word_d),
        .o_word_e     (o_word_e),
        .o_word_f     (o_word_f)
    );

endmodule

`default_nettype wire

// ===== src/idr_checker.sv =====
// idr_checker: port-level assertions for imu_reply_deframer, bound to the top level.
// Depends on idr_pkg.
`default_nettype none

module idr_checker (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           o_out_valid,
    input  wire logic           i_out_stall,
    input  wire logic           o_outcome,
    input  wire logic [1:0]     o_frame_kind,
    input  wire logic [31:0]    o_word_a,
    input  wire logic [31:0]    o_word_b,
    input  wire logic [31:0]    o_word_c,
    input  wire logic [31:0]    o_word_d,
    input  wire logic [31:0]    o_word_e,
    input  wire logic [31:0]    o_word_f
);

    // a stalled result stays valid, with outcome, kind and words a, c and f stable
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_outcome) && $stable(o_frame_kind) &&
            $stable(o_word_a) && $stable(o_word_c) && $stable(o_word_f))
        else $error("result changed under stall");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_frame_kind == idr_pkg::KIND_EULER) ||
                        (o_frame_kind == idr_pkg::KIND_RATE) ||
                        (o_frame_kind == idr_pkg::KIND_DELTA))
        else $error("illegal frame kind");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_outcome == idr_pkg::OUTCOME_BAD) |->
            o_word_a == '0 && o_word_b == '0 && o_word_c == '0 &&
            o_word_d == '0 && o_word_e == '0 && o_word_f == '0)
        else $error("mismatch result carries payload");

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_frame_kind == idr_pkg::KIND_EULER) |->
            o_word_d == '0 && o_word_e == '0 && o_word_f == '0)
        else $error("short frame carries rate words");

endmodule

bind imu_reply_deframer idr_checker u_idr_checker (.*);

`default_nettype wire
